### sv/decimal_text_to_int64_macros.svh
// Assertion macros used by the checker file.
`ifndef DECIMAL_TEXT_TO_INT64_MACROS_SVH
`define DECIMAL_TEXT_TO_INT64_MACROS_SVH

// Check on every edge outside reset.
`define DTI_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define DTI_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/dti64_pkg.sv
package dti64_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_string;
	} byte_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]         status;
	} res_item_t;

	// Converter state as it stands after the final byte of a string.
	typedef struct packed {
		logic        negative;
		logic        overflowed;
		logic        has_digits;
		logic [63:0] accumulator;
	} raw_res_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_DIGITS = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

endpackage

### sv/dti64_in_reg.sv
module dti64_in_reg import dti64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  byte_item_t byte_item,
	output logic       byte_stall,
	input  logic       advance,
	output logic       valid_s1,
	output byte_item_t item_s1
);

	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

endmodule

### sv/dti64_core.sv
module dti64_core import dti64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  byte_item_t item,
	output logic       emit,
	output raw_res_t   raw
);

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SKIP_WS,
		PH_SIGN,
		PH_NEED_DIGIT,
		PH_DIGITS,
		PH_DONE_OK,
		PH_DONE_NONE
	} phase_t;

	localparam logic [7:0]  CH_NUL   = 8'h00;
	localparam logic [7:0]  CH_TAB   = 8'h09;
	localparam logic [7:0]  CH_CR    = 8'h0D;
	localparam logic [7:0]  CH_SPACE = 8'h20;
	localparam logic [7:0]  CH_PLUS  = 8'h2B;
	localparam logic [7:0]  CH_MINUS = 8'h2D;
	localparam logic [7:0]  CH_ZERO  = 8'h30;
	localparam logic [7:0]  CH_NINE  = 8'h39;
	localparam logic [4:0]  MAX_SIG  = 5'd19;
	localparam logic [4:0]  SIG_SAT  = 5'd20;
	localparam logic [63:0] ACC_LIMIT = 64'd922337203685477580;

	phase_t      phase_q, phase_n;
	logic        neg_q, neg_n;
	logic        ovf_q, ovf_n;
	logic [63:0] acc_q, acc_n;
	logic [4:0]  sig_q, sig_n;

	logic        is_nul, is_sp, is_dig;
	logic [3:0]  dig;
	logic [4:0]  sig_inc;
	logic [63:0] acc_mul;
	logic        after_ws;
	logic        take;

	assign is_nul  = item.ch == CH_NUL;
	assign is_sp   = item.ch == CH_SPACE || (item.ch >= CH_TAB && item.ch <= CH_CR);
	assign is_dig  = item.ch >= CH_ZERO && item.ch <= CH_NINE;
	assign dig     = item.ch[3:0];
	assign sig_inc = (sig_q < SIG_SAT) ? sig_q + 5'd1 : sig_q;
	// times ten as shift-add; acc_q is at most the limit here, so no carry is lost
	assign acc_mul = (acc_q << 3) + (acc_q << 1) + {60'd0, dig};

	always_comb begin
		phase_n  = phase_q;
		neg_n    = neg_q;
		ovf_n    = ovf_q;
		acc_n    = acc_q;
		sig_n    = sig_q;
		after_ws = 1'b0;
		take     = 1'b0;
		if (!is_nul) begin
			case (phase_q)
				PH_FIRST: begin
					if (is_sp) phase_n = PH_SKIP_WS;
					else after_ws = 1'b1;
				end
				PH_SKIP_WS: begin
					if (!is_sp) after_ws = 1'b1;
				end
				PH_SIGN: after_ws = 1'b1;
				PH_NEED_DIGIT: begin
					if (is_dig) take = 1'b1;
					else phase_n = PH_DONE_NONE;
				end
				PH_DIGITS: begin
					if (is_dig) take = 1'b1;
					else phase_n = PH_DONE_OK;
				end
				PH_DONE_OK: ;
				default: phase_n = PH_DONE_NONE;
			endcase
		end
		if (after_ws) begin
			if (item.ch == CH_MINUS) begin
				neg_n   = 1'b1;
				phase_n = PH_NEED_DIGIT;
			end else if (item.ch == CH_PLUS) begin
				phase_n = PH_NEED_DIGIT;
			end else if (is_dig) begin
				take = 1'b1;
			end else begin
				phase_n = PH_DONE_NONE;
			end
		end
		if (take) begin
			phase_n = PH_DIGITS;
			// leading zeros leave the count alone
			if (!ovf_q && !(acc_q == 64'd0 && dig == 4'd0)) begin
				sig_n = sig_inc;
				if (sig_inc > MAX_SIG || acc_q > ACC_LIMIT) begin
					ovf_n = 1'b1;
				end else begin
					acc_n = acc_mul;
					if (acc_mul[63]) ovf_n = 1'b1;
				end
			end
		end
	end

	assign emit            = is_nul || item.end_of_string;
	assign raw.negative    = neg_n;
	assign raw.overflowed  = ovf_n;
	assign raw.has_digits  = phase_n == PH_DIGITS || phase_n == PH_DONE_OK;
	assign raw.accumulator = acc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			acc_q   <= 64'd0;
			sig_q   <= 5'd0;
		end else if (step) begin
			// a finished string leaves the converter ready for the next one
			if (emit) begin
				phase_q <= PH_FIRST;
				neg_q   <= 1'b0;
				ovf_q   <= 1'b0;
				acc_q   <= 64'd0;
				sig_q   <= 5'd0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				ovf_q   <= ovf_n;
				acc_q   <= acc_n;
				sig_q   <= sig_n;
			end
		end
	end

endmodule

### sv/dti64_out_reg.sv
module dti64_out_reg import dti64_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  raw_res_t  raw,
	output logic      ready,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	logic     valid_q;
	raw_res_t raw_q;

	assign ready     = !valid_q || !res_stall;
	assign res_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			raw_q <= raw;
		end
	end

	always_comb begin
		if (!raw_q.has_digits) begin
			res_item.value  = 64'sd0;
			res_item.status = ST_NO_DIGITS;
		end else if (raw_q.overflowed) begin
			res_item.value  = raw_q.negative ? -64'sd1 : 64'sd1;
			res_item.status = ST_OVERFLOW;
		end else begin
			res_item.value  = raw_q.negative ? -$signed(raw_q.accumulator)
			                                 : $signed(raw_q.accumulator);
			res_item.status = ST_OK;
		end
	end

endmodule

### sv/decimal_text_to_int64.sv
// A string's last byte passes the input register, then its result loads into the result register.
// One byte per cycle unless a full result register stalls; converter state updates once per byte.
// A byte waits in the input register only while the result register is full and stalled.
// Reset (arst_n low, asynchronous): both registers empty, converter awaits the first byte.
module decimal_text_to_int64 import dti64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	output logic       res_valid,
	input  logic       res_stall,
	output res_item_t  res_item
);

	logic       valid_s1;
	byte_item_t item_s1;
	logic       ready;
	logic       advance;
	logic       emit;
	raw_res_t   raw;

	assign advance = valid_s1 && ready;

	dti64_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_item  (byte_item),
		.byte_stall (byte_stall),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	dti64_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.emit   (emit),
		.raw    (raw)
	);

	dti64_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.raw       (raw),
		.ready     (ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

### sv/dti64_chk.sv
`include "decimal_text_to_int64_macros.svh"

module dti64_chk import dti64_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_stall,
	input byte_item_t byte_item,
	input logic       res_valid,
	input logic       res_stall,
	input res_item_t  res_item
);

	`DTI_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !res_valid, "result valid during reset")
	`DTI_ASSERT(a_hold_result, res_valid && res_stall |=> res_valid && $stable(res_item), "stalled result changed")
	`DTI_ASSERT(a_no_stall_when_empty, !res_valid |-> !byte_stall, "input stalled with result register empty")
	`DTI_ASSERT(a_status_code, res_valid |-> (res_item.status == ST_OK || res_item.status == ST_NO_DIGITS || res_item.status == ST_OVERFLOW), "bad status code")
	`DTI_ASSERT(a_special_values, res_valid && res_item.status != ST_OK |-> (res_item.status == ST_NO_DIGITS && res_item.value == 64'sd0) || (res_item.status == ST_OVERFLOW && (res_item.value == 64'sd1 || res_item.value == -64'sd1)), "value disagrees with status")

endmodule

bind decimal_text_to_int64 dti64_chk u_chk (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import dti64_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned BYTE_TARGET = 1900;
	localparam int unsigned MAX_SIG_DIGITS = 19;
	localparam logic [63:0] ACC_LIMIT = 64'd922337203685477580;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		P_FIRST, P_SKIP_WS, P_SIGN, P_NEED_DIGIT, P_DIGITS, P_DONE_OK, P_DONE_NONE
	} conv_phase_t;

	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

	typedef logic [7:0] text_q_t[$];

	class text_to_int_checker;
		conv_phase_t phase;
		bit          negative;
		logic [63:0] magnitude;
		int unsigned sig_digits;
		bit          overflowed;
		res_item_t   expected_values[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned overflows;
		int unsigned empties;

		function new();
			clear_state();
		endfunction

		function void clear_state();
			phase = P_FIRST;
			negative = 1'b0;
			magnitude = '0;
			sig_digits = 0;
			overflowed = 1'b0;
		endfunction

		function bit is_space(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		function void take_digit(logic [7:0] c);
			logic [63:0] d;
			d = {56'd0, c - CH_ZERO};
			phase = P_DIGITS;
			if (overflowed)
				return;
			// leading zeros are not significant
			if (magnitude == 0 && d == 0)
				return;
			if (sig_digits < 20)
				sig_digits++;
			if (sig_digits > MAX_SIG_DIGITS || magnitude > ACC_LIMIT) begin
				overflowed = 1'b1;
				return;
			end
			magnitude = magnitude * 10 + d;
			if (magnitude[63])
				overflowed = 1'b1;
		endfunction

		function void after_space(logic [7:0] c);
			if (c == CH_MINUS) begin
				negative = 1'b1;
				phase = P_NEED_DIGIT;
			end else if (c == CH_PLUS) begin
				phase = P_NEED_DIGIT;
			end else if (is_digit(c)) begin
				take_digit(c);
			end else begin
				phase = P_DONE_NONE;
			end
		endfunction

		function void step_text(logic [7:0] c);
			case (phase)
				P_FIRST: begin
					if (is_space(c))
						phase = P_SKIP_WS;
					else
						after_space(c);
				end
				P_SKIP_WS: begin
					if (!is_space(c))
						after_space(c);
				end
				P_SIGN: after_space(c);
				P_NEED_DIGIT: begin
					if (is_digit(c))
						take_digit(c);
					else
						phase = P_DONE_NONE;
				end
				P_DIGITS: begin
					if (is_digit(c))
						take_digit(c);
					else
						phase = P_DONE_OK;
				end
				P_DONE_OK: ;
				default: phase = P_DONE_NONE;
			endcase
		endfunction

		function void note_byte(byte_item_t b);
			res_item_t r;
			if (b.ch != CH_NUL)
				step_text(b.ch);
			// NUL ends the string whatever the end mark says
			if (b.ch != CH_NUL && !b.end_of_string)
				return;
			if (phase == P_DIGITS || phase == P_DONE_OK) begin
				if (overflowed) begin
					r.value = negative ? -64'sd1 : 64'sd1;
					r.status = ST_OVERFLOW;
				end else begin
					r.value = negative ? -magnitude : magnitude;
					r.status = ST_OK;
				end
			end else begin
				r.value = '0;
				r.status = ST_NO_DIGITS;
			end
			expected_values = {expected_values, r};
			clear_state();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(res_item_t got);
			res_item_t want;
			if (expected_values.size() == 0) begin
				report($sformatf("result with none pending: value %0d status %0d",
					got.value, got.status));
				return;
			end
			want = expected_values.pop_front();
			checked++;
			if (want.status == ST_OVERFLOW)
				overflows++;
			else if (want.status == ST_NO_DIGITS)
				empties++;
			if (got.value !== want.value)
				report($sformatf("value %0d, expected %0d", got.value, want.value));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	byte_item_t byte_item;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_item_t  res_item;

	text_to_int_checker conv = new();

	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	int unsigned bytes_sent = 0;
	int unsigned strings_sent = 0;
	int unsigned rx_left = 0;
	rx_mode_t    rx_mode = RX_FREE;

	decimal_text_to_int64 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				conv.expected_values.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall)
			conv.note_byte(byte_item);
		if (arst_n && res_valid && !res_stall)
			conv.check_result(res_item);
	end

	// receiver: switch at random between stall patterns
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 120);
		end
		rx_left--;
		case (rx_mode)
			RX_FREE:     res_stall <= 1'b0;
			RX_RANDOM:   res_stall <= ($urandom_range(0, 2) == 0);
			RX_PERIODIC: res_stall <= rx_left[2];
			default:     res_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] c, input logic eos);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				byte_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		byte_valid <= 1'b1;
		byte_item <= '{ch: c, end_of_string: eos};
		do @(posedge clk); while (byte_stall);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_text(input text_q_t t, input bit nul_end);
		foreach (t[i])
			send_byte(t[i], !nul_end && i == t.size() - 1);
		if (nul_end || t.size() == 0)
			send_byte(CH_NUL, 1'($urandom_range(0, 1)));
		strings_sent++;
	endtask

	// hold the sender until every pending result has arrived
	task automatic drain();
		byte_valid <= 1'b0;
		@(negedge clk);
		while (conv.expected_values.size() != 0)
			@(negedge clk);
	endtask

	function automatic text_q_t to_bytes(string s);
		text_q_t q;
		for (int i = 0; i < s.len(); i++)
			q = {q, s[i]};
		return q;
	endfunction

	function automatic text_q_t random_text();
		text_q_t q;
		int unsigned kind;
		kind = $urandom_range(0, 19);
		if (kind < 3) begin
			repeat ($urandom_range(1, 6))
				q = {q, 8'($urandom_range(0, 255))};
			return q;
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				q = {q, (($urandom_range(0, 5) == 0) ? CH_SPACE
					: 8'($urandom_range(CH_TAB, CH_CR)))};
		case ($urandom_range(0, 2))
			1: q = {q, CH_PLUS};
			2: q = {q, CH_MINUS};
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4))
				q = {q, CH_ZERO};
		if (kind < 5) begin
			// straddle the 2^63 boundary
			q = {q, to_bytes("92233720368547758")};
			repeat (2)
				q = {q, 8'(CH_ZERO + 8'($urandom_range(0, 9)))};
		end else begin
			repeat ((kind < 7) ? $urandom_range(17, 22) : $urandom_range(0, 12))
				q = {q, 8'(CH_ZERO + 8'($urandom_range(0, 9)))};
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3))
				q = {q, 8'($urandom_range(1, 255))};
		return q;
	endfunction

	initial begin
		text_q_t ws_text;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		ws_text = {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
		ws_text = {ws_text, to_bytes("-17x5")};
		send_text(to_bytes("0"), 1'b1);
		send_text(to_bytes(""), 1'b1);
		send_text(to_bytes("-9223372036854775808"), 1'b0);
		send_text(to_bytes("9223372036854775807"), 1'b1);
		send_text(to_bytes("9223372036854775808"), 1'b0);
		send_text(to_bytes("-12345678901234567890"), 1'b1);
		send_text(to_bytes("000000000000000000000042"), 1'b0);
		send_text(ws_text, 1'b1);
		send_text(to_bytes("+"), 1'b0);
		send_text(to_bytes("-"), 1'b1);
		send_text(to_bytes("+-5"), 1'b1);
		send_text(to_bytes("- 5"), 1'b0);
		send_text(to_bytes("abc"), 1'b1);
		send_text(to_bytes("12 34"), 1'b0);
		send_text(to_bytes("   "), 1'b1);
		send_text(to_bytes("-000"), 1'b0);
		send_text({8'hFF, to_bytes("1")}, 1'b1);
		drain();

		while (bytes_sent < BYTE_TARGET) begin
			send_text(random_text(), 1'($urandom_range(0, 1)));
			if (strings_sent % 150 == 0)
				drain();
		end

		byte_valid <= 1'b0;
		while (conv.expected_values.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);

		$display("sent %0d bytes in %0d strings; checked %0d results", bytes_sent,
			strings_sent, conv.checked);
		$display("of those %0d overflowed and %0d had no digits; %0d mismatches",
			conv.overflows, conv.empties, conv.mismatches);
		if (conv.mismatches == 0 && conv.expected_values.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### decimal_text_to_int64.f
+incdir+sv
sv/dti64_pkg.sv
sv/dti64_in_reg.sv
sv/dti64_core.sv
sv/dti64_out_reg.sv
sv/decimal_text_to_int64.sv
sv/dti64_chk.sv
tb/tb_top.sv
